// ===== sv/swsb_pkg.sv =====
package swsb_pkg;

   localparam int WINDOW_BITS_DEF = 4096;
   localparam int NUM_W           = 31;
   localparam int ALU_W           = 32;
   localparam int OPC_W           = 2;
   localparam int BYTE_W          = 8;
   localparam int BIT_IDX_W       = 3;
   localparam logic [BYTE_W-1:0] BYTE_ALL_UNREAD = 8'hff;

   typedef enum logic [OPC_W-1:0] {
      OP_QUERY       = 2'd0,
      OP_MARK_READ   = 2'd1,
      OP_MARK_UNREAD = 2'd2,
      OP_REINIT      = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

endpackage

// ===== sv/swsb_ifs.sv =====
interface swsb_req_if;
   logic                          valid;
   logic                          ready;
   logic [swsb_pkg::OPC_W-1:0]    opcode;
   logic [swsb_pkg::NUM_W-1:0]    text_number;

   modport source (output valid, output opcode, output text_number, input ready);
   modport sink   (input valid, input opcode, input text_number, output ready);
endinterface

interface swsb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          unread;
   logic [swsb_pkg::NUM_W-1:0]    window_start;

   modport source (output valid, output unread, output window_start, input ready);
   modport sink   (input valid, input unread, input window_start, output ready);
endinterface

interface swsb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [swsb_pkg::NUM_W-1:0]    first_text;

   modport source (output valid, output first_text, input ready);
   modport sink   (input valid, input first_text, output ready);
endinterface

// ===== sv/swsb_ram.sv =====
module swsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/swsb_alu.sv =====
module swsb_alu (
   input  swsb_pkg::alu_op_type          op,
   input  logic [swsb_pkg::ALU_W-1:0]    a,
   input  logic [swsb_pkg::ALU_W-1:0]    b,
   output logic [swsb_pkg::ALU_W-1:0]    y
);

   always_comb begin
      case (op)
         swsb_pkg::ALU_ADD: y = a + b;
         swsb_pkg::ALU_SUB: y = a - b;
         default:           y = a + b;
      endcase
   end

endmodule

// ===== sv/sliding_window_seen_bitmap_unit.sv =====
// channel    dir   transaction                    payload
// req_chan   in    one operation                  opcode, text_number
// rsp_chan   out   one result per operation       unread, window_start
// csr_chan   in    write of first_text            first_text
//
// Query and marks inside the window: offset, RAM read, update, result.
// Outside it, mark read above apart: offset, result. Reinit fills BYTE_COUNT
// bytes, one a cycle. Mark read above the window: the shared adder takes four
// steps for the window start, then fills min(k, BYTE_COUNT) bytes, one a cycle.
// After reset the bitmap RAM is set to all-unread, one byte a cycle, with
// req_chan.ready low.
// A finished result waits in the output register; a new transaction is taken
// meanwhile and held before its own result until rsp_chan is free.
// WINDOW_BITS must be a power of two.
module sliding_window_seen_bitmap_unit #(
   parameter int WINDOW_BITS = swsb_pkg::WINDOW_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   swsb_req_if.sink       req_chan,
   swsb_rsp_if.source     rsp_chan,
   swsb_csr_if.sink       csr_chan
);

   localparam int LOG2W      = $clog2(WINDOW_BITS);
   localparam int BYTE_COUNT = WINDOW_BITS / swsb_pkg::BYTE_W;
   localparam int BYTE_IDX_W = LOG2W - swsb_pkg::BIT_IDX_W;
   localparam int NUM_W      = swsb_pkg::NUM_W;
   localparam int ALU_W      = swsb_pkg::ALU_W;
   localparam int BYTE_W     = swsb_pkg::BYTE_W;
   localparam int BIT_IDX_W  = swsb_pkg::BIT_IDX_W;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b00_0000_0001,
      ST_IDLE   = 10'b00_0000_0010,
      ST_DIFF   = 10'b00_0000_0100,
      ST_EXCESS = 10'b00_0000_1000,
      ST_BYTES  = 10'b00_0001_0000,
      ST_BASE   = 10'b00_0010_0000,
      ST_FILL   = 10'b00_0100_0000,
      ST_READ   = 10'b00_1000_0000,
      ST_MODIFY = 10'b01_0000_0000,
      ST_RESP   = 10'b10_0000_0000
   } state_type;

   state_type                  state_ff, state_in;
   swsb_pkg::opcode_type       op_ff, op_in;
   logic [NUM_W-1:0]           num_ff, num_in;
   logic [NUM_W-1:0]           base_ff, base_in;
   logic [NUM_W-1:0]           first_text_ff, first_text_in;
   logic [ALU_W-1:0]           acc_ff, acc_in;
   logic [BYTE_IDX_W-1:0]      addr_ff, addr_in;
   logic [BYTE_IDX_W:0]        left_ff, left_in;
   logic                       unread_ff, unread_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_unread_ff, rsp_unread_in;
   logic [NUM_W-1:0]           rsp_start_ff, rsp_start_in;

   swsb_pkg::alu_op_type       alu_op;
   logic [ALU_W-1:0]           alu_a, alu_b, alu_y;
   logic                       below, above;

   logic                       ram_wr_en, ram_rd_en;
   logic [BYTE_IDX_W-1:0]      ram_wr_addr;
   logic [BYTE_W-1:0]          ram_wr_data, ram_rd_data, bit_mask;
   logic                       req_take;

   swsb_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   swsb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BYTE_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (num_ff[LOG2W-1:BIT_IDX_W]),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.unread       = rsp_unread_ff;
   assign rsp_chan.window_start = rsp_start_ff;

   assign bit_mask = BYTE_W'(1) << num_ff[BIT_IDX_W-1:0];
   assign below    = alu_y[ALU_W-1];
   assign above    = !below && (alu_y[ALU_W-2:LOG2W] != '0);

   always_comb begin
      alu_op = swsb_pkg::ALU_ADD;
      alu_a  = acc_ff;
      alu_b  = ALU_W'(1);
      case (state_ff)
         ST_DIFF: begin
            alu_op = swsb_pkg::ALU_SUB;
            alu_a  = {1'b0, num_ff};
            alu_b  = {1'b0, base_ff};
         end
         ST_EXCESS: begin
            alu_op = swsb_pkg::ALU_SUB;
            alu_a  = acc_ff;
            alu_b  = ALU_W'(WINDOW_BITS);
         end
         ST_BYTES: begin
            alu_op = swsb_pkg::ALU_ADD;
            alu_a  = {3'b000, acc_ff[ALU_W-1:3]};
            alu_b  = ALU_W'(1);
         end
         ST_BASE: begin
            alu_op = swsb_pkg::ALU_ADD;
            alu_a  = {1'b0, base_ff};
            alu_b  = {acc_ff[ALU_W-4:0], 3'b000};
         end
         default: begin
            alu_op = swsb_pkg::ALU_ADD;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      num_in        = num_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      addr_in       = addr_ff;
      left_in       = left_ff;
      unread_in     = unread_ff;
      rsp_unread_in = rsp_unread_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      first_text_in = csr_chan.valid ? csr_chan.first_text : first_text_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = addr_ff;
      ram_wr_data   = swsb_pkg::BYTE_ALL_UNREAD;
      ram_rd_en     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + 1'b1;
            left_in   = left_ff - 1'b1;
            if (left_ff == (BYTE_IDX_W+1)'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               op_in  = swsb_pkg::opcode_type'(req_chan.opcode);
               num_in = req_chan.text_number;
               if (swsb_pkg::opcode_type'(req_chan.opcode) == swsb_pkg::OP_REINIT) begin
                  base_in  = first_text_ff;
                  addr_in  = '0;
                  left_in  = (BYTE_IDX_W+1)'(BYTE_COUNT);
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            acc_in = alu_y;
            if (below) begin
               unread_in = 1'b0;
               state_in  = ST_RESP;
            end else if (above) begin
               unread_in = 1'b1;
               state_in  = (op_ff == swsb_pkg::OP_MARK_READ) ? ST_EXCESS : ST_RESP;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_EXCESS: begin
            acc_in   = alu_y;
            state_in = ST_BYTES;
         end
         ST_BYTES: begin
            acc_in   = alu_y;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            base_in = alu_y[NUM_W-1:0];
            addr_in = base_ff[LOG2W-1:BIT_IDX_W];
            if (acc_ff[ALU_W-1:BYTE_IDX_W] != '0) begin
               left_in = (BYTE_IDX_W+1)'(BYTE_COUNT);
            end else begin
               left_in = {1'b0, acc_ff[BYTE_IDX_W-1:0]};
            end
            state_in = ST_FILL;
         end
         ST_FILL: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + 1'b1;
            left_in   = left_ff - 1'b1;
            if (left_ff == (BYTE_IDX_W+1)'(1)) begin
               if (op_ff == swsb_pkg::OP_REINIT) begin
                  unread_in = 1'b1;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_MODIFY;
         end
         ST_MODIFY: begin
            ram_wr_addr = num_ff[LOG2W-1:BIT_IDX_W];
            state_in    = ST_RESP;
            case (op_ff)
               swsb_pkg::OP_MARK_READ: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data & ~bit_mask;
                  unread_in   = 1'b0;
               end
               swsb_pkg::OP_MARK_UNREAD: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data | bit_mask;
                  unread_in   = 1'b1;
               end
               default: begin
                  unread_in = ram_rd_data[num_ff[BIT_IDX_W-1:0]];
               end
            endcase
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_unread_in = unread_ff;
               rsp_start_in  = base_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         base_ff       <= '0;
         first_text_ff <= '0;
         addr_ff       <= '0;
         left_ff       <= (BYTE_IDX_W+1)'(BYTE_COUNT);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         first_text_ff <= first_text_in;
         addr_ff       <= addr_in;
         left_ff       <= left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      num_ff        <= num_in;
      acc_ff        <= acc_in;
      unread_ff     <= unread_in;
      rsp_unread_ff <= rsp_unread_in;
      rsp_start_ff  <= rsp_start_in;
   end

   a_reinit_base: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.opcode == swsb_pkg::OP_REINIT) |=> base_ff == $past(first_text_ff))
      else $error("reinit did not load window start");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL || state_ff == ST_CLEAR) |-> left_ff != '0)
      else $error("byte fill ran past its count");

   a_slide_forward: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BASE) |=> base_ff > $past(base_ff))
      else $error("window slide did not advance");

   a_mark_read_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && op_ff == swsb_pkg::OP_MARK_READ) |-> !unread_ff)
      else $error("mark read reported unread");

   a_ram_write_owner: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_FILL || state_ff == ST_CLEAR || state_ff == ST_MODIFY))
      else $error("bitmap written outside fill or update");

endmodule

// ===== tb/swsb_tb_pkg.sv =====
package swsb_tb_pkg;

   import swsb_pkg::*;

   localparam int unsigned WIN = WINDOW_BITS_DEF;
   localparam int unsigned MAP_BYTES = WIN / BYTE_W;
   localparam logic [NUM_W-1:0] NUM_MAX = '1;

   typedef struct packed {
      logic             unread;
      logic [NUM_W-1:0] start;
   } outcome_type;

   class seen_bitmap_scoreboard;
      logic [BYTE_W-1:0] unread_map [MAP_BYTES];
      logic [NUM_W-1:0]  base_nr;
      logic [NUM_W-1:0]  first_nr;
      outcome_type       awaited [$];
      int                failures;

      function new();
         foreach (unread_map[i]) unread_map[i] = BYTE_ALL_UNREAD;
         base_nr  = '0;
         first_nr = '0;
         failures = 0;
      endfunction

      function void write_first(logic [NUM_W-1:0] v);
         first_nr = v;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function logic flag_view(logic [NUM_W-1:0] n);
         longint unsigned lo;
         int unsigned     pos;
         lo  = base_nr;
         pos = n % WIN;
         if (n < lo) return 1'b0;
         if (n >= lo + WIN) return 1'b1;
         return unread_map[pos / BYTE_W][pos % BYTE_W];
      endfunction

      function void set_flag(logic [NUM_W-1:0] n, logic v);
         int unsigned pos;
         pos = n % WIN;
         unread_map[pos / BYTE_W][pos % BYTE_W] = v;
      endfunction

      function outcome_type apply_operation(opcode_type op, logic [NUM_W-1:0] n);
         longint unsigned lo, hi, nn, nbytes, fill;
         int unsigned     first_byte;
         outcome_type     r;
         lo = base_nr;
         hi = lo + WIN;
         nn = n;
         r.unread = 1'b1;
         if (op == OP_REINIT) begin
            base_nr = first_nr;
            foreach (unread_map[i]) unread_map[i] = BYTE_ALL_UNREAD;
         end else begin
            if (op == OP_MARK_READ && nn >= lo) begin
               if (nn >= hi) begin
                  // slide in whole bytes, vacated bytes come back all unread
                  nbytes     = (nn - hi) / BYTE_W + 1;
                  fill       = (nbytes < MAP_BYTES) ? nbytes : MAP_BYTES;
                  first_byte = 32'((hi % WIN) / BYTE_W);
                  for (longint unsigned i = 0; i < fill; i++)
                     unread_map[(first_byte + i) % MAP_BYTES] = BYTE_ALL_UNREAD;
                  base_nr = NUM_W'(lo + nbytes * BYTE_W);
               end
               set_flag(n, 1'b0);
            end else if (op == OP_MARK_UNREAD && nn >= lo && nn < hi) begin
               set_flag(n, 1'b1);
            end
            r.unread = flag_view(n);
         end
         r.start = base_nr;
         return r;
      endfunction

      function void note_request(opcode_type op, logic [NUM_W-1:0] n);
         awaited.push_back(apply_operation(op, n));
      endfunction

      function void check_response(logic u, logic [NUM_W-1:0] ws);
         outcome_type e;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: unread=%0b window_start=%0d", u, ws);
            return;
         end
         e = awaited.pop_front();
         if (u !== e.unread || ws !== e.start) begin
            failures++;
            if (failures <= 10)
               $display({"result wrong: expected unread=%0b window_start=%0d, ",
                         "got unread=%0b window_start=%0d"},
                        e.unread, e.start, u, ws);
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_sliding_window_seen_bitmap_unit.sv =====
module tb_sliding_window_seen_bitmap_unit;

   import swsb_pkg::*;
   import swsb_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int          LONG_HOLD   = 300;
   localparam int          PHASES      = 6;
   localparam int          PHASE_ITEMS = 200;

   logic clock = 1'b0;
   logic reset;

   swsb_req_if req_chan ();
   swsb_rsp_if rsp_chan ();
   swsb_csr_if csr_chan ();

   seen_bitmap_scoreboard sb = new();

   int unsigned      cycles = 0;
   int               hold_asks = 0;
   bit               send_idles;
   logic [NUM_W-1:0] cursor;
   logic [NUM_W-1:0] first_values [PHASES];

   sliding_window_seen_bitmap_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [NUM_W-1:0] clamp_nr(longint v);
      if (v < 0) return '0;
      if (v > longint'(NUM_MAX)) return NUM_MAX;
      return NUM_W'(v);
   endfunction

   task automatic send_op(opcode_type op, logic [NUM_W-1:0] n);
      int gap;
      gap = send_idles ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= op;
      req_chan.text_number <= n;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(op, n);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_first_text(logic [NUM_W-1:0] v);
      csr_chan.valid      <= 1'b1;
      csr_chan.first_text <= v;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      sb.write_first(v);
   endtask

   // mostly sequential reading around the window, some jumps, reinits and noise
   task automatic random_item();
      int         pick;
      longint     base;
      opcode_type op;
      pick = $urandom_range(0, 99);
      base = sb.base_nr;
      if (cursor < sb.base_nr) cursor = sb.base_nr;
      if (pick < 4) begin
         send_op(OP_REINIT, NUM_W'($urandom));
         cursor = sb.base_nr;
      end else if (pick < 12) begin
         send_op(opcode_type'($urandom_range(0, 2)), NUM_W'($urandom));
      end else if (pick < 18) begin
         send_op(OP_MARK_READ, clamp_nr(base + WIN + longint'($urandom_range(0, 2 * WIN))));
      end else if (pick < 55) begin
         send_op(pick < 48 ? OP_MARK_READ : OP_QUERY, cursor);
         cursor = clamp_nr(longint'(cursor) + longint'($urandom_range(1, 4)));
      end else begin
         op = opcode_type'($urandom_range(0, 2));
         send_op(op, clamp_nr(base + longint'($urandom_range(0, WIN + 80)) - 40));
      end
   endtask

   initial begin : receiver
      int hold;
      int seen_asks;
      int got;
      bit rcv_idles;
      rsp_chan.ready <= 1'b0;
      seen_asks = 0;
      got       = 0;
      rcv_idles = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (got % 32 == 0) rcv_idles = $urandom_range(0, 2) != 0;
         hold = rcv_idles ? $urandom_range(0, 5) : 0;
         if (hold_asks != seen_asks) begin
            hold += LONG_HOLD;
            seen_asks = hold_asks;
         end
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         sb.check_response(rsp_chan.unread, rsp_chan.window_start);
         got++;
      end
   end

   initial begin : stimulus
      req_chan.valid       <= 1'b0;
      req_chan.opcode      <= OP_QUERY;
      req_chan.text_number <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.first_text  <= '0;
      reset                <= 1'b1;
      send_idles = 1'b0;
      first_values[0] = 31'd5;
      first_values[1] = NUM_MAX;
      first_values[2] = '0;
      first_values[3] = 31'h7fff_f7fd;
      first_values[4] = NUM_W'($urandom);
      first_values[5] = NUM_W'($urandom_range(0, 1 << 20));
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // window starts at 0 after reset
      send_op(OP_QUERY,       31'd0);
      send_op(OP_MARK_READ,   31'd0);
      send_op(OP_QUERY,       31'd0);
      send_op(OP_MARK_UNREAD, 31'd0);
      send_op(OP_MARK_READ,   31'd7);
      send_op(OP_MARK_READ,   31'd4095);
      send_op(OP_QUERY,       31'd4096);
      send_op(OP_MARK_UNREAD, 31'd4096);
      send_op(OP_MARK_READ,   31'd4096);
      send_op(OP_QUERY,       31'd0);
      send_op(OP_MARK_READ,   31'd3);
      send_op(OP_MARK_UNREAD, 31'd5);
      send_op(OP_QUERY,       31'd4095);
      send_op(OP_MARK_READ,   31'd16389);
      send_op(OP_MARK_READ,   NUM_MAX);
      send_op(OP_QUERY,       NUM_MAX);
      send_op(OP_MARK_UNREAD, NUM_MAX);
      send_op(OP_QUERY,       31'd0);
      send_op(OP_REINIT,      NUM_MAX);
      send_op(OP_QUERY,       NUM_MAX);
      send_op(OP_MARK_READ,   31'd4103);
      send_op(OP_QUERY,       31'd4);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_first_text(first_values[p]);
         send_op(OP_REINIT, '0);
         cursor = sb.base_nr;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) send_idles = $urandom_range(0, 2) != 0;
            if (i == 60 && p % 2 == 1) hold_asks++;
            random_item();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
